FILE: rtl/adws_pkg.sv
package adws_pkg;

    // Geometry of the list and widths of the fixed payload fields.
    localparam int DEPTH  = 16;
    localparam int WIDTH  = 32;
    localparam int KIND_W = 3;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 4;
    localparam int CNT_W  = 5;
    localparam int STAT_W = 3;

    typedef enum logic [KIND_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_SEARCH     = 3'd4,
        OP_REPLACE    = 3'd5,
        OP_RSVD6      = 3'd6,
        OP_RSVD7      = 3'd7
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_RANGE     = 3'd4
    } stat_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;
        logic  exec;
        logic  commit;
        op_t   op;
        stat_t status;
    } ctl_cmd_t;

    // Conditions reported by the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic hit;
        logic idx_ok;
    } dp_flags_t;

endpackage

FILE: rtl/adws_ctrl.sv
module adws_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [adws_pkg::KIND_W-1:0]       kind,
    input  adws_pkg::dp_flags_t               flags,
    output adws_pkg::ctl_cmd_t                cmd,
    output logic                              busy
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t          state_reg, state_next;
    adws_pkg::op_t   kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= adws_pkg::OP_PUSH_FRONT;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign busy = (state_reg == S_EXEC);

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.op     = kind_reg;
        cmd.status = adws_pkg::ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    kind_next  = adws_pkg::op_t'(kind);
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_IDLE;
                case (kind_reg)
                    adws_pkg::OP_PUSH_FRONT, adws_pkg::OP_PUSH_REAR:
                    begin
                        cmd.commit = !flags.full;
                        cmd.status = flags.full ? adws_pkg::ST_FULL : adws_pkg::ST_OK;
                    end
                    adws_pkg::OP_POP_FRONT, adws_pkg::OP_POP_REAR:
                    begin
                        cmd.commit = !flags.empty;
                        cmd.status = flags.empty ? adws_pkg::ST_EMPTY : adws_pkg::ST_OK;
                    end
                    adws_pkg::OP_SEARCH:
                    begin
                        cmd.status = flags.hit ? adws_pkg::ST_OK : adws_pkg::ST_NOT_FOUND;
                    end
                    adws_pkg::OP_REPLACE:
                    begin
                        cmd.commit = flags.idx_ok;
                        cmd.status = flags.idx_ok ? adws_pkg::ST_OK : adws_pkg::ST_RANGE;
                    end
                    default:
                    begin
                        cmd.status = adws_pkg::ST_OK;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/adws_dp.sv
module adws_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  adws_pkg::ctl_cmd_t                  cmd,
    input  logic signed [adws_pkg::VAL_W-1:0]   value,
    input  logic [adws_pkg::POS_W-1:0]          index,
    output adws_pkg::dp_flags_t                 flags,
    output logic                                done,
    output logic [adws_pkg::STAT_W-1:0]         status,
    output logic [adws_pkg::POS_W-1:0]          found_position,
    output logic [adws_pkg::CNT_W-1:0]          entry_count
);

    logic [adws_pkg::WIDTH-1:0] entries_reg [adws_pkg::DEPTH];
    logic [adws_pkg::WIDTH-1:0] entries_next [adws_pkg::DEPTH];
    logic [adws_pkg::WIDTH-1:0] word_reg;
    logic [adws_pkg::POS_W-1:0] index_reg;
    logic [adws_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       done_reg;
    logic [adws_pkg::STAT_W-1:0] status_reg;
    logic [adws_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [adws_pkg::DEPTH-1:0] match;
    logic [adws_pkg::POS_W-1:0] hit_pos;

    // The incoming word is sign-extended or cut to the stored width.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg  <= adws_pkg::WIDTH'(value);
            index_reg <= index;
        end
    end

    // Parallel compare over the live entries, lowest position wins.
    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < adws_pkg::DEPTH; i++)
        begin
            match[i] = (entries_reg[i] == word_reg) &&
                       (adws_pkg::CNT_W'(i) < count_reg);
        end
        for (int i = adws_pkg::DEPTH - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_pos = adws_pkg::POS_W'(i);
            end
        end
    end

    assign flags.full   = (count_reg == adws_pkg::CNT_W'(adws_pkg::DEPTH));
    assign flags.empty  = (count_reg == '0);
    assign flags.hit    = |match;
    assign flags.idx_ok = ({1'b0, index_reg} < count_reg);

    always_comb
    begin
        for (int i = 0; i < adws_pkg::DEPTH; i++)
        begin
            entries_next[i] = entries_reg[i];
        end
        count_next = count_reg;
        if (cmd.exec && cmd.commit)
        begin
            case (cmd.op)
                adws_pkg::OP_PUSH_FRONT:
                begin
                    entries_next[0] = word_reg;
                    for (int i = 1; i < adws_pkg::DEPTH; i++)
                    begin
                        entries_next[i] = entries_reg[i-1];
                    end
                    count_next = count_reg + 1'b1;
                end
                adws_pkg::OP_PUSH_REAR:
                begin
                    entries_next[count_reg[adws_pkg::POS_W-1:0]] = word_reg;
                    count_next = count_reg + 1'b1;
                end
                adws_pkg::OP_POP_FRONT:
                begin
                    for (int i = 0; i < adws_pkg::DEPTH - 1; i++)
                    begin
                        entries_next[i] = entries_reg[i+1];
                    end
                    count_next = count_reg - 1'b1;
                end
                adws_pkg::OP_POP_REAR:
                begin
                    count_next = count_reg - 1'b1;
                end
                adws_pkg::OP_REPLACE:
                begin
                    entries_next[index_reg] = word_reg;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        pos_next = '0;
        if (cmd.op == adws_pkg::OP_SEARCH && flags.hit)
        begin
            pos_next = hit_pos;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < adws_pkg::DEPTH; i++)
        begin
            entries_reg[i] <= entries_next[i];
        end
        if (cmd.exec)
        begin
            status_reg <= cmd.status;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.exec;
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign found_position = pos_reg;
    assign entry_count    = count_reg;

endmodule

FILE: rtl/array_deque_with_search.sv
// A command accepted at one clock edge is executed in the next cycle,
// and its result beat appears with done high in the cycle after that.
// No new command is taken while busy; busy is high for the single execute
// cycle, so a new start is taken in the same cycle that done is shown.
// Reset (rst_n low, asynchronous): the list becomes empty and no beat is pending.
// The receiver cannot stall; each result beat is valid for exactly one cycle.
module array_deque_with_search (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [adws_pkg::KIND_W-1:0]         kind,
    input  logic signed [adws_pkg::VAL_W-1:0]   value,
    input  logic [adws_pkg::POS_W-1:0]          index,
    output logic                                busy,
    output logic                                done,
    output logic [adws_pkg::STAT_W-1:0]         status,
    output logic [adws_pkg::POS_W-1:0]          found_position,
    output logic [adws_pkg::CNT_W-1:0]          entry_count
);

    // The controller sequences each command: it captures the kind, then in
    // the execute cycle turns the datapath's conditions (full, empty, hit,
    // index in range) into a status code and decides whether the list is
    // changed.
    adws_pkg::ctl_cmd_t  cmd;
    adws_pkg::dp_flags_t flags;

    adws_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .flags (flags),
        .cmd   (cmd),
        .busy  (busy)
    );

    // The datapath holds the entries in registers so that a front insert or
    // remove shifts every entry at once and a search compares all of them in
    // parallel. It also registers the result beat.
    adws_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .value          (value),
        .index          (index),
        .flags          (flags),
        .done           (done),
        .status         (status),
        .found_position (found_position),
        .entry_count    (entry_count)
    );

endmodule

FILE: rtl/adws_checker.sv
module adws_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                done,
    input logic [adws_pkg::STAT_W-1:0]         status,
    input logic [adws_pkg::CNT_W-1:0]          entry_count
);

    // Every accepted command yields exactly one beat, after its execute cycle.
    a_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("no result beat two cycles after an accepted command");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted command");

    a_no_spurious_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result beat without a preceding execute cycle");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (entry_count <= adws_pkg::CNT_W'(adws_pkg::DEPTH)))
        else $error("entry count beyond list depth");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == adws_pkg::ST_EMPTY) |-> (entry_count == '0))
        else $error("empty status with entries held");

endmodule

bind array_deque_with_search adws_checker u_adws_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .entry_count (entry_count)
);
